[rtl/ptd_pkg.sv]
`timescale 1ns / 1ps

package ptd_pkg;

   localparam int MAX_TASKS = 8;
   localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   localparam logic [1:0] KIND_TICK     = 2'd0;
   localparam logic [1:0] KIND_START    = 2'd1;
   localparam logic [1:0] KIND_DISPATCH = 2'd2;

   localparam logic [31:0]      IDLE_NONE = 32'hFFFF_FFFF;
   localparam logic [31:0]      REM_MIN   = 32'h8000_0000;
   localparam logic [CNT_W-1:0] SLOTS_ALL = CNT_W'(MAX_TASKS);

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [14:0] delay_ms;
      logic [14:0] period_ms;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        dispatched;
      logic [2:0]  task_index;
      logic [31:0] idle_ms;
   } rsp_type;

   // slot load from a start request
   typedef struct packed {
      logic [14:0] delay_ms;
      logic [14:0] period_ms;
   } slot_write_type;

   // dispatch token walking the cell row
   typedef struct packed {
      logic              valid;
      logic [31:0]       elapsed;
      logic              dispatched;
      logic [SLOT_W-1:0] index;
      logic [31:0]       idle;
   } token_type;

endpackage

[rtl/ptd_cell.sv]
`timescale 1ns / 1ps

module ptd_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [ptd_pkg::SLOT_W-1:0] cell_idx,
   input  logic                      wr_en,
   input  ptd_pkg::slot_write_type   wr,
   input  ptd_pkg::token_type        tok_prev,
   output ptd_pkg::token_type        tok_next
);
   import ptd_pkg::*;

   logic        run_ff, run_in;
   logic [31:0] rem_ff, rem_in;
   logic [14:0] per_ff, per_in;
   token_type   token_ff, token_in;

   logic [33:0] diff;
   logic        under;
   logic        due;
   logic        take;
   logic [31:0] rem_sub;
   logic [31:0] rem_reload;

   always_comb begin
      // saturating subtract of elapsed time, signed 32-bit result
      diff       = {{2{rem_ff[31]}}, rem_ff} - {2'b00, tok_prev.elapsed};
      under      = diff[33] & ~(diff[32] & diff[31]);
      rem_sub    = under ? REM_MIN : diff[31:0];
      due        = rem_sub[31] | (rem_sub == '0);
      take       = due & ~tok_prev.dispatched;
      rem_reload = rem_sub + {17'd0, per_ff};

      run_in   = run_ff;
      rem_in   = rem_ff;
      per_in   = per_ff;
      token_in = tok_prev;

      if (wr_en) begin
         run_in = 1'b1;
         rem_in = {17'd0, wr.delay_ms};
         per_in = wr.period_ms;
      end else if (tok_prev.valid && run_ff) begin
         rem_in = take ? rem_reload : rem_sub;
         if (take) begin
            token_in.dispatched = 1'b1;
            token_in.index      = cell_idx;
         end
         if (due) begin
            token_in.idle = '0;
         end else if (rem_sub < tok_prev.idle) begin
            token_in.idle = rem_sub;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      per_ff <= per_in;
      if (reset) begin
         run_ff   <= 1'b0;
         token_ff <= '0;
      end else begin
         run_ff   <= run_in;
         token_ff <= token_in;
      end
   end

   assign tok_next = token_ff;

endmodule

[rtl/periodic_task_dispatcher_top.sv]
`timescale 1ns / 1ps

// Periodic task dispatcher.
// Request channel (req_*): one request per item, kind tick, start or dispatch.
// Response channel (rsp_*): exactly one response per request, in order.
// A tick or a start request answers on the cycle after it is taken, and a
// new tick or start can be taken every cycle while the response is not stalled.
// A dispatch request launches a token down a row of MAX_TASKS slot cells,
// one cell per cycle; each cell ages its task, checks whether it is due and
// folds its remaining time into the idle minimum. The response is registered
// once the token leaves the last cell, and no other request is taken while
// the token walks the row.
// Reset clears the ms count, the last dispatch time, the slot fill count and
// every slot's running bit; slot timers are loaded when a start claims them.
// The response sits in an output register; while rsp_stall is high it holds
// and req_stall rises once a new request would need that register.
module periodic_task_dispatcher_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptd_pkg::rsp_type rsp_data
);
   import ptd_pkg::*;

   state_type        state_ff, state_in;
   logic [31:0]      ms_ff, ms_in;
   logic [31:0]      last_ff, last_in;
   logic [CNT_W-1:0] slots_ff, slots_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   token_type        inject_ff, inject_in;

   token_type        chain [MAX_TASKS+1];
   logic [MAX_TASKS-1:0] chain_valid;
   logic [MAX_TASKS-1:0] wr_en;
   slot_write_type   wr;

   logic req_accept;
   logic rsp_take;
   logic chain_done;
   logic start_ok;
   logic is_dispatch;

   assign req_accept  = req_valid & ~req_stall;
   assign rsp_take    = rsp_valid_ff & ~rsp_stall;
   assign chain_done  = chain[MAX_TASKS].valid;
   assign is_dispatch = req_data.kind == KIND_DISPATCH;
   assign start_ok    = req_accept && (req_data.kind == KIND_START) && (slots_ff < SLOTS_ALL);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && is_dispatch) state_in = S_WALK;
         end
         S_WALK: begin
            if (chain_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs: one request in flight at a time
   always_comb begin
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE:  req_stall = rsp_valid_ff & rsp_stall;
         S_WALK:  req_stall = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   // request decode and response load
   always_comb begin
      ms_in        = ms_ff;
      last_in      = last_ff;
      slots_in     = slots_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_take;
      rsp_data_in  = rsp_data_ff;
      inject_in    = '0;

      if (req_accept) begin
         rsp_data_in = '0;
         unique case (req_data.kind)
            KIND_TICK: begin
               ms_in        = ms_ff + 32'd1;
               rsp_valid_in = 1'b1;
            end
            KIND_START: begin
               if (start_ok) begin
                  slots_in             = slots_ff + CNT_W'(1);
                  rsp_data_in.accepted = 1'b1;
               end
               rsp_valid_in = 1'b1;
            end
            KIND_DISPATCH: begin
               last_in           = ms_ff;
               inject_in.valid   = 1'b1;
               inject_in.elapsed = ms_ff - last_ff;
               inject_in.idle    = IDLE_NONE;
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end

      if (chain_done) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.accepted   = 1'b0;
         rsp_data_in.dispatched = chain[MAX_TASKS].dispatched;
         rsp_data_in.task_index = 3'(chain[MAX_TASKS].index);
         rsp_data_in.idle_ms    = chain[MAX_TASKS].idle;
      end
   end

   assign wr.delay_ms  = req_data.delay_ms;
   assign wr.period_ms = req_data.period_ms;
   assign chain[0]     = inject_ff;

   genvar g;
   generate
      for (g = 0; g < MAX_TASKS; g++) begin : g_cell
         assign wr_en[g]       = start_ok && (slots_ff == CNT_W'(g));
         assign chain_valid[g] = chain[g+1].valid;

         ptd_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (SLOT_W'(g)),
            .wr_en    (wr_en[g]),
            .wr       (wr),
            .tok_prev (chain[g]),
            .tok_next (chain[g+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         ms_ff        <= '0;
         last_ff      <= '0;
         slots_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         inject_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         ms_ff        <= ms_in;
         last_ff      <= last_in;
         slots_ff     <= slots_in;
         rsp_valid_ff <= rsp_valid_in;
         inject_ff    <= inject_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // response register is empty while a token walks the row
   a_walk_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> !rsp_valid_ff)
      else $error("response pending during dispatch walk");

   // at most one token in the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one dispatch token in flight");

   // a token leaves the row only while walking
   a_done_in_walk: assert property (@(posedge clock) disable iff (reset)
      chain_done |-> (state_ff == S_WALK))
      else $error("dispatch token finished outside walk");

   // fill count never passes the slot count
   a_slots_bound: assert property (@(posedge clock) disable iff (reset)
      slots_ff <= SLOTS_ALL)
      else $error("slot fill count overflow");

endmodule
